>>> rtl/hsnu_pkg.sv
// Shared constants for the heat stencil node update block.
package hsnu_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int COEF_REG_W  = 16;
  localparam int SOURCE_W    = 32;
  localparam int NUM_SIDES   = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_COEF_X       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_Y       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FIXED_SIDES  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SIDE_LOSSES  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_LEFT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_RIGHT = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_LOW   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HIGH  = 3'd7;

  localparam int SIDE_LEFT  = 0;
  localparam int SIDE_RIGHT = 1;
  localparam int SIDE_LOW   = 2;
  localparam int SIDE_HIGH  = 3;

endpackage

>>> rtl/hsnu_in_if.sv
// Input channel carrying one node and its neighbors per word.
interface hsnu_in_if #(
  parameter int TEMP_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [TEMP_WIDTH-1:0] center_temp;
  logic signed [TEMP_WIDTH-1:0] east_temp;
  logic signed [TEMP_WIDTH-1:0] west_temp;
  logic signed [TEMP_WIDTH-1:0] north_temp;
  logic signed [TEMP_WIDTH-1:0] south_temp;
  logic                         on_left_edge;
  logic                         on_right_edge;
  logic                         on_low_edge;
  logic                         on_high_edge;

  modport source (
    output valid, center_temp, east_temp, west_temp, north_temp, south_temp,
    output on_left_edge, on_right_edge, on_low_edge, on_high_edge,
    input  ready
  );
  modport sink (
    input  valid, center_temp, east_temp, west_temp, north_temp, south_temp,
    input  on_left_edge, on_right_edge, on_low_edge, on_high_edge,
    output ready
  );
endinterface

>>> rtl/hsnu_out_if.sv
// Output channel carrying one updated temperature per word.
interface hsnu_out_if #(
  parameter int TEMP_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [TEMP_WIDTH-1:0] new_temp;
  logic                         saturated;

  modport source (output valid, new_temp, saturated, input ready);
  modport sink (input valid, new_temp, saturated, output ready);
endinterface

>>> rtl/heat_stencil_node_update_top.sv
// Top level of the explicit 2D heat-equation node update pipeline.
// This block computes one node of an explicit heat-equation time step from the node's old
// temperature, its four neighbors and its edge flags, and returns the saturated new
// temperature with a flag that reports clipping. It takes one word per cycle while the
// output is not stalled, and each result passes through an input register, a stage that
// forms the six coefficient products, and a stage that sums the terms and saturates into
// the output register. Each stage holds its word while the stage after it is full and
// stalled, so the input keeps accepting until the pipeline fills.
// Configuration registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while the pipeline is empty, as the block does not enforce it.
module heat_stencil_node_update_top
  import hsnu_pkg::*;
#(
  parameter int TEMP_WIDTH = 32,
  parameter int COEF_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  hsnu_in_if.sink                node_in,
  hsnu_out_if.source             node_out
);

  localparam int TW    = TEMP_WIDTH;
  localparam int CW    = COEF_WIDTH;
  localparam int CL    = (CW < COEF_REG_W) ? CW : COEF_REG_W;
  localparam int DW    = TW + 2;
  localparam int PFW   = CW + 1 + DW;
  localparam int PW    = PFW - CW;
  localparam int LFW   = CW + 1 + TW;
  localparam int LW    = LFW - CW;
  localparam int ACC_W = ((TW > SOURCE_W) ? TW : SOURCE_W) + 5;

  logic [COEF_REG_W-1:0]      coef_x;
  logic [COEF_REG_W-1:0]      coef_y;
  logic [NUM_SIDES-1:0]       fixed_sides;
  logic [CFG_DATA_W-1:0]      side_losses;
  logic signed [SOURCE_W-1:0] source [NUM_SIDES];

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x      <= '0;
      coef_y      <= '0;
      fixed_sides <= '0;
      side_losses <= '0;
      for (int i = 0; i < NUM_SIDES; i++) begin
        source[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_X:       coef_x <= cfg_data[COEF_REG_W-1:0];
        REG_COEF_Y:       coef_y <= cfg_data[COEF_REG_W-1:0];
        REG_FIXED_SIDES:  fixed_sides <= cfg_data[NUM_SIDES-1:0];
        REG_SIDE_LOSSES:  side_losses <= cfg_data;
        REG_SOURCE_LEFT:  source[SIDE_LEFT] <= cfg_data[SOURCE_W-1:0];
        REG_SOURCE_RIGHT: source[SIDE_RIGHT] <= cfg_data[SOURCE_W-1:0];
        REG_SOURCE_LOW:   source[SIDE_LOW] <= cfg_data[SOURCE_W-1:0];
        REG_SOURCE_HIGH:  source[SIDE_HIGH] <= cfg_data[SOURCE_W-1:0];
        default: ;
      endcase
    end
  end

  logic load1, load2, load3;

  logic                 v1;
  logic signed [TW-1:0] t1, e1, w1, n1, s1;
  logic [NUM_SIDES-1:0] edge1;

  logic                 v2;
  logic                 hold2;
  logic signed [TW-1:0] t2;
  logic signed [PW-1:0] px2, py2;
  logic signed [LW-1:0] loss2 [NUM_SIDES];
  logic [NUM_SIDES-1:0] edge2;

  logic                 ov;
  logic signed [TW-1:0] new_temp;
  logic                 saturated;

  assign load3 = !ov || node_out.ready;
  assign load2 = !v2 || load3;
  assign load1 = !v1 || load2;

  assign node_in.ready      = load1;
  assign node_out.valid     = ov;
  assign node_out.new_temp  = new_temp;
  assign node_out.saturated = saturated;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (load1) begin
      v1 <= node_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      t1    <= node_in.center_temp;
      e1    <= node_in.east_temp;
      w1    <= node_in.west_temp;
      n1    <= node_in.north_temp;
      s1    <= node_in.south_temp;
      edge1 <= {node_in.on_high_edge, node_in.on_low_edge,
                node_in.on_right_edge, node_in.on_left_edge};
    end
  end

  logic signed [DW-1:0]  t_d, e_d, w_d, n_d, s_d, dx, dy;
  logic [CW-1:0]         cx_eff, cy_eff;
  logic signed [PFW-1:0] px_full, py_full;
  logic signed [LFW-1:0] loss_full [NUM_SIDES];
  logic [CW-1:0]         lane_eff [NUM_SIDES];

  assign t_d = DW'(t1);
  assign e_d = DW'(e1);
  assign w_d = DW'(w1);
  assign n_d = DW'(n1);
  assign s_d = DW'(s1);

  always_comb begin
    priority if (edge1[SIDE_LEFT] && edge1[SIDE_RIGHT]) begin
      dx = '0;
    end else if (edge1[SIDE_LEFT]) begin
      dx = (e_d <<< 1) - (t_d <<< 1);
    end else if (edge1[SIDE_RIGHT]) begin
      dx = (w_d <<< 1) - (t_d <<< 1);
    end else begin
      dx = e_d + w_d - (t_d <<< 1);
    end
    priority if (edge1[SIDE_LOW] && edge1[SIDE_HIGH]) begin
      dy = '0;
    end else if (edge1[SIDE_LOW]) begin
      dy = (n_d <<< 1) - (t_d <<< 1);
    end else if (edge1[SIDE_HIGH]) begin
      dy = (s_d <<< 1) - (t_d <<< 1);
    end else begin
      dy = n_d + s_d - (t_d <<< 1);
    end
  end

  assign cx_eff  = CW'(coef_x[CL-1:0]);
  assign cy_eff  = CW'(coef_y[CL-1:0]);
  assign px_full = PFW'(signed'({1'b0, cx_eff})) * PFW'(dx);
  assign py_full = PFW'(signed'({1'b0, cy_eff})) * PFW'(dy);

  always_comb begin
    for (int i = 0; i < NUM_SIDES; i++) begin
      lane_eff[i]  = CW'(side_losses[COEF_REG_W*i +: CL]);
      loss_full[i] = LFW'(signed'({1'b0, lane_eff[i]})) * LFW'(t1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (load2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      hold2 <= |(edge1 & fixed_sides);
      t2    <= t1;
      px2   <= px_full[PFW-1:CW];
      py2   <= py_full[PFW-1:CW];
      edge2 <= edge1;
      for (int i = 0; i < NUM_SIDES; i++) begin
        loss2[i] <= loss_full[i][LFW-1:CW];
      end
    end
  end

  logic signed [ACC_W-1:0] acc;
  logic                    acc_ovf;
  logic signed [TW-1:0]    new_temp_next;
  logic                    saturated_next;

  always_comb begin
    acc = ACC_W'(t2) + ACC_W'(px2) + ACC_W'(py2);
    for (int i = 0; i < NUM_SIDES; i++) begin
      if (edge2[i]) begin
        acc = acc + ACC_W'(source[i]) - ACC_W'(loss2[i]);
      end
    end
    acc_ovf = (acc[ACC_W-1:TW-1] != '0) && (acc[ACC_W-1:TW-1] != '1);
    if (hold2) begin
      new_temp_next  = t2;
      saturated_next = 1'b0;
    end else if (acc_ovf) begin
      new_temp_next  = acc[ACC_W-1] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
      saturated_next = 1'b1;
    end else begin
      new_temp_next  = acc[TW-1:0];
      saturated_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load3) begin
      ov <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      new_temp  <= new_temp_next;
      saturated <= saturated_next;
    end
  end

`ifndef SYNTH
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    node_out.valid && node_out.saturated |->
      (node_out.new_temp == {1'b1, {(TW-1){1'b0}}}) ||
      (node_out.new_temp == {1'b0, {(TW-1){1'b1}}}))
    else $error("Saturated word does not hold a range limit.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !node_out.valid && !v1 && !v2)
    else $error("Pipeline not empty after reset.");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    node_in.valid && node_in.ready |=> v1)
    else $error("Accepted word did not reach the input register.");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    v2 && load3 |=> node_out.valid)
    else $error("Summed word did not reach the output register.");

  a_fixed_unclipped: assert property (@(posedge clk) disable iff (rst)
    v2 && hold2 && load3 |=> !node_out.saturated && node_out.new_temp == $past(t2))
    else $error("Fixed node did not keep its temperature.");
`endif

endmodule
